// File: sv/mkd_pkg.sv
// Package for the matrix keypad debouncer: sizes, queue entry and status types,
// and the seven-segment hex table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

    // Keypad geometry and debounce depth.
    localparam int HISTORY_LENGTH = 10;
    localparam int COLUMN_COUNT   = 4;
    localparam int ROW_COUNT      = 4;

    // Widths of column, sense, key, segment, digit, position and index fields.
    localparam int COLUMN_W   = 2;
    localparam int SENSE_W    = 4;
    localparam int KEY_W      = 4;
    localparam int SEG_W      = 8;
    localparam int DIGIT_W    = 8;
    localparam int POSITION_W = 3;
    localparam int COL_IDX_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int ROW_IDX_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    // Event queue between the classifier and the result serializer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [POSITION_W-1:0] DIGIT_POSITION_RESET = POSITION_W'(7);

    // One queued sample: its column, the keys that became pressed and the
    // digit select that was in force when it was taken.
    typedef struct packed {
        logic [COLUMN_W-1:0]  column;
        logic [ROW_COUNT-1:0] fall_mask;
        logic [DIGIT_W-1:0]   digit_select;
    } t_event;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Common-anode hex pattern (active low segments) for a key number.
    function automatic logic [SEG_W-1:0] hex_segments(input logic [KEY_W-1:0] idx);
        logic [SEG_W-1:0] seg;
        case (idx)
            4'h0: seg = 8'hC0;
            4'h1: seg = 8'hF9;
            4'h2: seg = 8'hA4;
            4'h3: seg = 8'hB0;
            4'h4: seg = 8'h99;
            4'h5: seg = 8'h92;
            4'h6: seg = 8'h82;
            4'h7: seg = 8'hF8;
            4'h8: seg = 8'h80;
            4'h9: seg = 8'h90;
            4'hA: seg = 8'h88;
            4'hB: seg = 8'h83;
            4'hC: seg = 8'hC6;
            4'hD: seg = 8'hA1;
            4'hE: seg = 8'h86;
            4'hF: seg = 8'h8E;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// File: sv/mkd_front.sv
// Front part of the keypad debouncer: accepts scan samples, keeps the
// per-key shift histories and stable levels, and classifies new presses.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [mkd_pkg::COLUMN_W-1:0]      i_column,
    input  wire logic [mkd_pkg::SENSE_W-1:0]       i_sense_levels,
    input  wire logic [mkd_pkg::DIGIT_W-1:0]       i_digit_select,
    input  wire mkd_pkg::t_queue_status            i_queue_status,
    output logic                                   o_push,
    output mkd_pkg::t_event                        o_event
);

    logic                                 w_accept;
    logic                                 w_col_ok;
    logic [mkd_pkg::COL_IDX_W-1:0]        w_col_idx;
    logic [mkd_pkg::ROW_COUNT-1:0]        w_fall;

    // An item is taken whenever the queue has room for its events.
    assign o_in_ready = !i_queue_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_col_ok   = 32'(i_column) < mkd_pkg::COLUMN_COUNT;
    assign w_col_idx  = mkd_pkg::COL_IDX_W'(i_column);

    // One lane per row; each lane holds the keys of that row, one per column.
    for (genvar r = 0; r < mkd_pkg::ROW_COUNT; r++) begin : g_lane
        logic [mkd_pkg::HISTORY_LENGTH-1:0] r_hist [mkd_pkg::COLUMN_COUNT];
        logic [mkd_pkg::COLUMN_COUNT-1:0]   r_stable;
        logic [mkd_pkg::HISTORY_LENGTH-1:0] w_hist_new;
        logic                               w_bit;
        logic                               w_prev;
        logic                               w_now;

        // Rows without a sense bit always read as released.
        if (r < mkd_pkg::SENSE_W) begin : g_sensed
            assign w_bit = i_sense_levels[r];
        end else begin : g_unsensed
            assign w_bit = 1'b1;
        end

        assign w_hist_new = {r_hist[w_col_idx][mkd_pkg::HISTORY_LENGTH-2:0], w_bit};
        assign w_prev     = r_stable[w_col_idx];

        // All low means pressed, all high means released, else hold.
        always_comb begin
            w_now = w_prev;
            if (&w_hist_new) begin
                w_now = 1'b1;
            end else if (~|w_hist_new) begin
                w_now = 1'b0;
            end
        end

        assign w_fall[r] = w_prev && !w_now;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                for (int c = 0; c < mkd_pkg::COLUMN_COUNT; c++) begin
                    r_hist[c] <= '1;
                end
                r_stable <= '1;
            end else if (w_accept && w_col_ok) begin
                r_hist[w_col_idx]   <= w_hist_new;
                r_stable[w_col_idx] <= w_now;
            end
        end
    end

    // Only samples that cause at least one press go into the queue.
    assign o_push               = w_accept && w_col_ok && (|w_fall);
    assign o_event.column       = i_column;
    assign o_event.fall_mask    = w_fall;
    assign o_event.digit_select = i_digit_select;

endmodule

`default_nettype wire

// File: sv/mkd_queue.sv
// Short event queue between the debouncer front and the result serializer.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mkd_pkg::t_event    i_event,
    input  wire logic               i_pop,
    output mkd_pkg::t_event         o_event,
    output mkd_pkg::t_queue_status  o_status
);

    localparam int CountW = mkd_pkg::QUEUE_AW + 1;

    mkd_pkg::t_event                r_entry [mkd_pkg::QUEUE_DEPTH];
    logic [mkd_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [mkd_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [CountW-1:0]              r_count;

    assign o_status.full  = (r_count == CountW'(mkd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_event        = r_entry[r_rd_ptr];

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_event;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(mkd_pkg::QUEUE_DEPTH))
        else $error("event queue count above depth");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("event queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("event queue underflow");

endmodule

`default_nettype wire

// File: sv/mkd_back.sv
// Back part of the keypad debouncer: walks the pressed keys of the queued
// sample in row order and presents one result item per key in an output
// register. Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mkd_pkg::t_event                i_event,
    input  wire mkd_pkg::t_queue_status         i_queue_status,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [mkd_pkg::KEY_W-1:0]           o_key_index,
    output logic [mkd_pkg::SEG_W-1:0]           o_segment_code,
    output logic [mkd_pkg::DIGIT_W-1:0]         o_digit_select,
    output logic                                o_last_of_run
);

    logic [mkd_pkg::ROW_COUNT-1:0]  r_done;
    logic [mkd_pkg::ROW_COUNT-1:0]  n_done;
    logic                           r_out_valid;
    logic [mkd_pkg::KEY_W-1:0]      r_key_index;
    logic [mkd_pkg::SEG_W-1:0]      r_segment_code;
    logic [mkd_pkg::DIGIT_W-1:0]    r_digit_select;
    logic                           r_last_of_run;

    logic [mkd_pkg::ROW_COUNT-1:0]  w_remaining;
    logic [mkd_pkg::ROW_COUNT-1:0]  w_sel_onehot;
    logic [mkd_pkg::ROW_IDX_W-1:0]  w_sel_row;
    logic                           w_more;
    logic                           w_load;
    logic [mkd_pkg::KEY_W-1:0]      w_key;

    // Keys of the head sample not yet sent.
    assign w_remaining = i_event.fall_mask & ~r_done;

    // Pick the lowest remaining row.
    always_comb begin
        w_sel_row = '0;
        for (int r = mkd_pkg::ROW_COUNT - 1; r >= 0; r--) begin
            if (w_remaining[r]) begin
                w_sel_row = mkd_pkg::ROW_IDX_W'(r);
            end
        end
    end

    assign w_sel_onehot = mkd_pkg::ROW_COUNT'(1) << w_sel_row;
    assign w_more       = |(w_remaining & ~w_sel_onehot);
    assign w_key        = mkd_pkg::KEY_W'(32'(i_event.column) * mkd_pkg::ROW_COUNT
                                          + 32'(w_sel_row));

    // With a sample queued, load the output register if empty or being taken.
    assign w_load = !i_queue_status.empty && (!r_out_valid || i_out_ready);
    assign o_pop  = w_load && !w_more;

    always_comb begin
        n_done = r_done;
        if (o_pop) begin
            n_done = '0;
        end else if (w_load) begin
            n_done = r_done | w_sel_onehot;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= n_done;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key_index    <= w_key;
            r_segment_code <= ~mkd_pkg::hex_segments(w_key);
            r_digit_select <= i_event.digit_select;
            r_last_of_run  <= !w_more;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_index    = r_key_index;
    assign o_segment_code = r_segment_code;
    assign o_digit_select = r_digit_select;
    assign o_last_of_run  = r_last_of_run;

    // A result that is not the last of its sample is followed at once.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !r_last_of_run) |=> r_out_valid)
        else $error("result run broken before its last item");

endmodule

`default_nettype wire

// File: sv/matrix_keypad_debouncer.sv
// Top level of the 4x4 matrix keypad debouncer.
// Depends on mkd_pkg, mkd_front, mkd_queue and mkd_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one scan sample per item:
//   the driven column and its four active-low row levels. Each key keeps a
//   ten-sample history; a key whose debounced level falls to pressed yields
//   one result item on the output channel (o_out_valid / i_out_ready), in row
//   order, with its key number, inverted hex segment code, inverted digit
//   select and a flag on the final result of that sample.
//   Throughput: one sample per cycle while the four-entry event queue has
//   room; results leave at one per cycle from the output register while
//   the receiver is ready.
//   The first result of a sample is queued when the sample is accepted and
//   is loaded into the output register once that register is free.
//   Samples that press no key produce nothing and use no queue slot.
//   Reset: all histories and debounced levels go to released, the queue
//   empties and the digit position returns to 7.
//   When the receiver stalls, the result holds in the output register, the
//   queue fills, and o_in_ready drops once four samples with presses wait.
//   i_cfg_we writes the digit position; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_debouncer (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mkd_pkg::POSITION_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [mkd_pkg::COLUMN_W-1:0]       i_column,
    input  wire logic [mkd_pkg::SENSE_W-1:0]        i_sense_levels,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [mkd_pkg::KEY_W-1:0]               o_key_index,
    output logic [mkd_pkg::SEG_W-1:0]               o_segment_code,
    output logic [mkd_pkg::DIGIT_W-1:0]             o_digit_select,
    output logic                                    o_last_of_run
);

    logic [mkd_pkg::POSITION_W-1:0]  r_digit_position;
    logic [mkd_pkg::DIGIT_W-1:0]     w_digit_select;
    logic                            w_push;
    logic                            w_pop;
    mkd_pkg::t_event                 w_push_event;
    mkd_pkg::t_event                 w_head_event;
    mkd_pkg::t_queue_status          w_queue_status;

    // Digit position register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_position <= mkd_pkg::DIGIT_POSITION_RESET;
        end else if (i_cfg_we) begin
            r_digit_position <= i_cfg_data;
        end
    end

    // Active-low one-hot digit select.
    assign w_digit_select = ~(mkd_pkg::DIGIT_W'(1) << r_digit_position);

    mkd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_column       (i_column),
        .i_sense_levels (i_sense_levels),
        .i_digit_select (w_digit_select),
        .i_queue_status (w_queue_status),
        .o_push         (w_push),
        .o_event        (w_push_event)
    );

    mkd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_event  (w_push_event),
        .i_pop    (w_pop),
        .o_event  (w_head_event),
        .o_status (w_queue_status)
    );

    mkd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_event        (w_head_event),
        .i_queue_status (w_queue_status),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_index    (o_key_index),
        .o_segment_code (o_segment_code),
        .o_digit_select (o_digit_select),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for matrix_keypad_debouncer: directed scan table plus random
// keypad scanning, checked against a debounce predictor kept in the testbench.
// Depends on mkd_pkg and the matrix_keypad_debouncer RTL.
`timescale 1ns / 1ps

module tb;

    // One expected key press result.
    typedef struct packed {
        logic [mkd_pkg::KEY_W-1:0]   key_index;
        logic [mkd_pkg::SEG_W-1:0]   segments;
        logic [mkd_pkg::DIGIT_W-1:0] digit_sel;
        logic                        last_flag;
    } t_press;

    // One row of the directed scan table. A typed row replaces the predicted
    // results of its final repetition with the results typed in the row.
    typedef struct packed {
        logic [mkd_pkg::COLUMN_W-1:0] column;
        logic [mkd_pkg::SENSE_W-1:0]  sense;
        int                           reps;
        bit                           typed;
        int                           typed_n;
        t_press                       typed_res;
        int                           position;
    } t_scan_row;

    // Common-anode hex patterns, active-low segments.
    localparam logic [mkd_pkg::SEG_W-1:0] SEG_PATTERN [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
    };

    localparam int KEYS = mkd_pkg::COLUMN_COUNT * mkd_pkg::ROW_COUNT;
    localparam int NO_WRITE = -1;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [mkd_pkg::POSITION_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [mkd_pkg::COLUMN_W-1:0]   i_column = '0;
    logic [mkd_pkg::SENSE_W-1:0]    i_sense_levels = '1;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [mkd_pkg::KEY_W-1:0]      o_key_index;
    logic [mkd_pkg::SEG_W-1:0]      o_segment_code;
    logic [mkd_pkg::DIGIT_W-1:0]    o_digit_select;
    logic                           o_last_of_run;

    // Predictor state: per-key sample trail, debounced level and shown digit.
    logic [mkd_pkg::HISTORY_LENGTH-1:0] sample_trail [KEYS];
    logic                               settled_up [KEYS];
    logic [mkd_pkg::POSITION_W-1:0]     shown_digit = mkd_pkg::DIGIT_POSITION_RESET;

    t_press pending_presses [$];
    int     errors = 0;
    int     results_seen = 0;
    bit     no_gaps = 1'b0;
    bit     held [KEYS];

    // Directed scan table.
    t_scan_row script [13] = '{
        // Released keys after reset give nothing.
        '{2'd2, 4'hF, 3,  1'b1, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        // Lowest key, default digit position.
        '{2'd0, 4'hE, 10, 1'b1, 1, '{4'd0,  8'h3F, 8'h7F, 1'b1}, NO_WRITE},
        // Rest of column 0 falls; the key already down stays silent.
        '{2'd0, 4'h0, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        // Release of a whole column emits nothing.
        '{2'd0, 4'hF, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        // Highest key.
        '{2'd3, 4'h7, 10, 1'b1, 1, '{4'd15, 8'h71, 8'h7F, 1'b1}, NO_WRITE},
        // A bounce in the middle of a press restarts the count.
        '{2'd1, 4'h0, 9,  1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        '{2'd1, 4'hF, 1,  1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        '{2'd1, 4'h0, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        // Alternating rows, then the other rows while the first release.
        '{2'd2, 4'hA, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        '{2'd2, 4'h5, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        '{2'd3, 4'h8, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, NO_WRITE},
        // Lowest digit position.
        '{2'd1, 4'hF, 10, 1'b0, 0, '{4'd0,  8'h00, 8'h00, 1'b0}, 0},
        '{2'd1, 4'hD, 10, 1'b1, 1, '{4'd5,  8'h6D, 8'hFE, 1'b1}, NO_WRITE}
    };

    matrix_keypad_debouncer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_column       (i_column),
        .i_sense_levels (i_sense_levels),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_index    (o_key_index),
        .o_segment_code (o_segment_code),
        .o_digit_select (o_digit_select),
        .o_last_of_run  (o_last_of_run)
    );

    // Clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver stalls at random unless a no-gap stretch is running.
    always @(posedge i_clk) begin
        i_out_ready <= no_gaps || ($urandom_range(0, 99) >= 16);
    end

    // Predictor state starts released.
    initial begin
        foreach (sample_trail[k]) begin
            sample_trail[k] = '1;
            settled_up[k] = 1'b1;
            held[k] = 1'b0;
        end
    end

    task automatic flag_error(input string what);
        errors++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Shifts one sample into the keys of a column and, when post is set,
    // queues a result for every key whose debounced level falls.
    function automatic void shift_in_column(input logic [mkd_pkg::COLUMN_W-1:0] col,
                                            input logic [mkd_pkg::SENSE_W-1:0] lv,
                                            input bit post);
        t_press                             hits [$];
        logic [mkd_pkg::HISTORY_LENGTH-1:0] trail;
        logic [mkd_pkg::KEY_W-1:0]          k;
        logic                               was_up;
        logic                               now_up;
        for (int row = 0; row < mkd_pkg::ROW_COUNT; row++) begin
            k = mkd_pkg::KEY_W'(col * mkd_pkg::ROW_COUNT + row);
            trail = {sample_trail[k][mkd_pkg::HISTORY_LENGTH-2:0], lv[row]};
            sample_trail[k] = trail;
            was_up = settled_up[k];
            now_up = was_up;
            if (&trail) now_up = 1'b1;
            else if (trail == '0) now_up = 1'b0;
            settled_up[k] = now_up;
            if (was_up && !now_up)
                hits.push_back('{k, ~SEG_PATTERN[k], ~(8'd1 << shown_digit), 1'b0});
        end
        if (hits.size() > 0) hits[hits.size() - 1].last_flag = 1'b1;
        if (post) foreach (hits[i]) pending_presses.push_back(hits[i]);
    endfunction

    // Offers one sample, holding it until accepted, then predicts its results.
    task automatic send_sample(input logic [mkd_pkg::COLUMN_W-1:0] col,
                               input logic [mkd_pkg::SENSE_W-1:0] lv, input bit post);
        while (!no_gaps && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_column       <= col;
        i_sense_levels <= lv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        shift_in_column(col, lv, post);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_presses.size() != 0);
    endtask

    // Writes the digit position once the block is idle.
    task automatic write_position(input logic [mkd_pkg::POSITION_W-1:0] pos);
        settle();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pos;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shown_digit = pos;
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_press want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_presses.size() == 0) begin
                flag_error($sformatf("result with nothing pending, key %0d", o_key_index));
            end else begin
                want = pending_presses.pop_front();
                if (o_key_index !== want.key_index)
                    flag_error($sformatf("key_index %0d, expected %0d",
                                         o_key_index, want.key_index));
                if (o_segment_code !== want.segments)
                    flag_error($sformatf("segment_code %h, expected %h (key %0d)",
                                         o_segment_code, want.segments, want.key_index));
                if (o_digit_select !== want.digit_sel)
                    flag_error($sformatf("digit_select %h, expected %h (key %0d)",
                                         o_digit_select, want.digit_sel, want.key_index));
                if (o_last_of_run !== want.last_flag)
                    flag_error($sformatf("last_of_run %b, expected %b (key %0d)",
                                         o_last_of_run, want.last_flag, want.key_index));
            end
        end
    end

    // Stimulus: reset, directed table, then random scanning in phases.
    initial begin
        logic [mkd_pkg::POSITION_W-1:0] phase_pos [5];
        logic [mkd_pkg::COLUMN_W-1:0]   col;
        logic [mkd_pkg::SENSE_W-1:0]    lv;
        bit                             final_rep;
        int                             scan_col;
        int                             count;
        int                             key;
        scan_col = 0;
        phase_pos[0] = 3'd7;
        phase_pos[1] = mkd_pkg::POSITION_W'($urandom_range(1, 6));
        phase_pos[2] = 3'd3;
        phase_pos[3] = 3'd0;
        phase_pos[4] = mkd_pkg::POSITION_W'($urandom_range(0, 7));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        foreach (script[r]) begin
            if (script[r].position != NO_WRITE)
                write_position(mkd_pkg::POSITION_W'(script[r].position));
            for (int n = 0; n < script[r].reps; n++) begin
                final_rep = script[r].typed && (n == script[r].reps - 1);
                send_sample(script[r].column, script[r].sense, !final_rep);
                if (final_rep && script[r].typed_n == 1)
                    pending_presses.push_back(script[r].typed_res);
            end
        end

        // Random scanning of a keypad whose keys go down and up with bounce,
        // mixed with some pure noise samples.
        for (int p = 0; p < 5; p++) begin
            write_position(phase_pos[p]);
            no_gaps = (p == 2);
            count = 0;
            while (count < 54) begin
                if ($urandom_range(0, 99) < 10) begin
                    col = mkd_pkg::COLUMN_W'($urandom_range(0, mkd_pkg::COLUMN_COUNT - 1));
                    lv = mkd_pkg::SENSE_W'($urandom_range(0, 15));
                end else begin
                    if ($urandom_range(0, 19) == 0)
                        col = mkd_pkg::COLUMN_W'($urandom_range(0,
                                                                mkd_pkg::COLUMN_COUNT - 1));
                    else
                        col = mkd_pkg::COLUMN_W'(scan_col);
                    scan_col = (scan_col + 1) % mkd_pkg::COLUMN_COUNT;
                    for (int row = 0; row < mkd_pkg::ROW_COUNT; row++) begin
                        key = col * mkd_pkg::ROW_COUNT + row;
                        if ($urandom_range(0, 15) == 0) held[key] = !held[key];
                        lv[row] = !held[key] ^ ($urandom_range(0, 23) == 0);
                    end
                end
                // Now and then let the block drain completely before going on.
                if ((p == 0 && count == 40) || $urandom_range(0, 39) == 0) settle();
                send_sample(col, lv, 1'b1);
                count++;
            end
        end

        no_gaps = 1'b0;
        settle();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake or results that never come.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
sv/mkd_pkg.sv
sv/mkd_front.sv
sv/mkd_queue.sv
sv/mkd_back.sv
sv/matrix_keypad_debouncer.sv
tb/tb.sv
